FILE: hdl/stbu_pkg.sv
// stbu_pkg: shared types, codes and sizes of the software timer bank
// used by stbu_cell and software_timer_bank_unit; depends on nothing
package stbu_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int TIME_BITS = 24;

    localparam int TIME_W = TIME_BITS + 1;
    localparam int DIFF_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;
    localparam int DLY_W  = (TIME_BITS > 24) ? TIME_BITS : 24;
    localparam logic [DLY_W-1:0] TIME_MAX = DLY_W'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic signed [DIFF_W-1:0] TIME_MIN = -(DIFF_W'(64'd1 << TIME_BITS));

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_START = 2'd1,
        K_STOP  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_ONESHOT  = 2'd0,
        MODE_COUNT    = 2'd1,
        MODE_FOREVER  = 2'd2,
        MODE_RESERVED = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_FIRED    = 3'd0,
        EV_STARTED  = 3'd1,
        EV_STOPPED  = 3'd2,
        EV_TICKDONE = 3'd3,
        EV_FULL     = 3'd4,
        EV_INACTIVE = 3'd5
    } t_event;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_TICK = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  mode;
        logic [23:0] delay;
        logic [15:0] repeat_count;
        logic [2:0]  slot;
    } t_in_word;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] slot_id;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic                 shift;
        logic                 visit;
        logic                 start;
        logic                 stop;
        logic [15:0]          step;
        logic [1:0]           mode;
        logic [TIME_BITS-1:0] delay;
        logic [15:0]          count;
    } t_cell_ctl;

    function automatic logic [TIME_BITS-1:0] sat_delay(input logic [23:0] d_in);
        logic [DLY_W-1:0] d;
        d = DLY_W'(d_in);
        if (d > TIME_MAX) begin
            d = TIME_MAX;
        end
        return TIME_BITS'(d);
    endfunction

endpackage

FILE: hdl/stbu_cell.sv
// stbu_cell: one timer slot of the chain, holds its state and passes the visit token
// depends on stbu_pkg
module stbu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stbu_pkg::t_cell_ctl i_ctl,
    input  logic                i_sel,
    input  logic                i_tok,
    output logic                o_tok,
    input  logic                i_taken,
    output logic                o_taken,
    output logic                o_fire,
    output logic                o_take,
    output logic                o_hit
);
    import stbu_pkg::*;

    logic                     r_active, n_active;
    logic [1:0]               r_mode, n_mode;
    logic signed [TIME_W-1:0] r_time, n_time;
    logic [TIME_BITS-1:0]     r_reload, n_reload;
    logic [15:0]              r_firings, n_firings;
    logic                     r_tok;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_sat;
    logic signed [TIME_W-1:0] reload_t;
    logic                     le0;
    logic                     visit;

    assign o_tok   = r_tok;
    assign o_taken = i_taken | ~r_active;
    assign o_take  = i_ctl.start & ~r_active & ~i_taken;
    assign o_hit   = i_ctl.stop & i_sel & r_active;
    assign visit   = r_tok & i_ctl.visit & r_active;

    always_comb begin
        diff     = DIFF_W'(r_time) - DIFF_W'($signed({1'b0, i_ctl.step}));
        diff_sat = (diff < TIME_MIN) ? TIME_MIN : diff;
        le0      = (diff <= 0);
        reload_t = TIME_W'($signed({1'b0, r_reload}));

        n_active  = r_active;
        n_mode    = r_mode;
        n_time    = r_time;
        n_reload  = r_reload;
        n_firings = r_firings;
        o_fire    = 1'b0;

        if (visit) begin
            n_time = TIME_W'(diff_sat);
            case (r_mode)
                MODE_ONESHOT: begin
                    if (le0) begin
                        o_fire   = 1'b1;
                        n_active = 1'b0;
                    end
                end
                MODE_COUNT: begin
                    if (r_firings == 16'd0) begin
                        n_active = 1'b0;
                    end else if (le0) begin
                        o_fire    = 1'b1;
                        n_time    = reload_t;
                        n_firings = r_firings - 16'd1;
                    end
                end
                default: begin
                    if (le0) begin
                        o_fire = 1'b1;
                        n_time = reload_t;
                    end
                end
            endcase
        end

        if (o_take) begin
            n_active  = 1'b1;
            n_mode    = (i_ctl.mode == MODE_RESERVED) ? MODE_FOREVER : i_ctl.mode;
            n_time    = TIME_W'($signed({1'b0, i_ctl.delay}));
            n_reload  = i_ctl.delay;
            n_firings = i_ctl.count;
        end

        if (o_hit) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_mode   <= 2'd0;
            r_tok    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_mode   <= n_mode;
            if (i_ctl.shift) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time    <= n_time;
        r_reload  <= n_reload;
        r_firings <= n_firings;
    end

endmodule

FILE: hdl/software_timer_bank_unit.sv
// software_timer_bank_unit: top level, a chain of stbu_cell slots with a tick sequencer
// and a registered result stage; depends on stbu_pkg and stbu_cell
//
// usage: an input word (kind tick, start or stop) is taken when i_in_valid is high
// and o_in_stall is low. results leave on the output channel, one word per
// accepted o_out_valid with i_out_stall low; the final word of each input has last set.
// start and stop give one registered result word in the cycle after acceptance; an input
// of kind three gives none. a tick hands a visit token down the slot chain, one slot per
// cycle while the receiver does not stall, emitting a fired word for each slot that fires,
// then a tick done word. o_in_stall stays high while a tick runs.
// a stalled receiver holds the result register and freezes the token walk until
// the word is taken. tick_step is written through i_cfg_valid / i_cfg_data
// (o_cfg_ready is always high) and resets to 256. after reset all slots are free.
module software_timer_bank_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stbu_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stbu_pkg::t_out_word  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);
    import stbu_pkg::*;

    t_state    r_state, n_state;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out, n_out;
    logic [15:0] r_step;

    t_cell_ctl ctl;
    logic [NUM_SLOTS:0]   tok;
    logic [NUM_SLOTS:0]   taken;
    logic [NUM_SLOTS-1:0] fire;
    logic [NUM_SLOTS-1:0] take;
    logic [NUM_SLOTS-1:0] hit;
    logic [NUM_SLOTS-1:0] sel;

    logic       load_ok;
    logic       in_acc;
    logic       any_tok;
    logic       tick_adv;
    logic       tick_end;
    logic [2:0] fire_id;
    logic [2:0] take_id;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign tok[0]      = in_acc & (i_in_data.kind == K_TICK);
    assign taken[0]    = 1'b0;

    always_comb begin
        fire_id = 3'd0;
        take_id = 3'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel[i] = (32'(i_in_data.slot) == i);
            if (fire[i]) begin
                fire_id = 3'(i);
            end
            if (take[i]) begin
                take_id = 3'(i);
            end
        end
    end

    always_comb begin
        load_ok    = ~r_out_valid | ~i_out_stall;
        o_in_stall = ~((r_state == ST_IDLE) & load_ok);
        in_acc     = i_in_valid & ~o_in_stall;
        any_tok    = |tok[NUM_SLOTS:1];
        tick_adv   = (r_state == ST_TICK) & load_ok & any_tok;
        tick_end   = (r_state == ST_TICK) & load_ok & ~any_tok;

        ctl.shift = tick_adv | (in_acc & (i_in_data.kind == K_TICK));
        ctl.visit = tick_adv;
        ctl.start = in_acc & (i_in_data.kind == K_START);
        ctl.stop  = in_acc & (i_in_data.kind == K_STOP);
        ctl.step  = r_step;
        ctl.mode  = i_in_data.mode;
        ctl.delay = sat_delay(i_in_data.delay);
        ctl.count = i_in_data.repeat_count;

        n_state     = r_state;
        n_out_valid = load_ok ? 1'b0 : r_out_valid;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.kind)
                        K_TICK: begin
                            n_state = ST_TICK;
                        end
                        K_START: begin
                            n_out_valid     = 1'b1;
                            n_out.event_res = taken[NUM_SLOTS] ? EV_STARTED : EV_FULL;
                            n_out.slot_id   = taken[NUM_SLOTS] ? take_id : 3'd0;
                            n_out.last      = 1'b1;
                        end
                        K_STOP: begin
                            n_out_valid     = 1'b1;
                            n_out.event_res = (|hit) ? EV_STOPPED : EV_INACTIVE;
                            n_out.slot_id   = i_in_data.slot;
                            n_out.last      = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (tick_adv && (|fire)) begin
                    n_out_valid     = 1'b1;
                    n_out.event_res = EV_FIRED;
                    n_out.slot_id   = fire_id;
                    n_out.last      = 1'b0;
                end else if (tick_end) begin
                    n_out_valid     = 1'b1;
                    n_out.event_res = EV_TICKDONE;
                    n_out.slot_id   = 3'd0;
                    n_out.last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        stbu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_sel   (sel[g]),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_taken (taken[g]),
            .o_taken (taken[g+1]),
            .o_fire  (fire[g]),
            .o_take  (take[g]),
            .o_hit   (hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= 16'd256;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_step <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
